// ----- src/lmfs_pkg.sv -----
package lmfs_pkg;

   // Default sizes of the block
   localparam int QUEUE_DEPTH_DEFAULT   = 10;
   localparam int MESSAGE_BYTES_DEFAULT = 8;

   // Result field width, fixed by the interface
   localparam int BIT_INDEX_WIDTH = 7;

   // Register reset value
   localparam logic [7:0] STATION_ID_RESET = 8'd87;

   // Fixed frame bytes
   localparam logic [7:0] FRAME_SYNC  = 8'h55;
   localparam logic [7:0] FRAME_SYN   = 8'h16;
   localparam logic [7:0] FRAME_STX   = 8'h02;
   localparam logic [7:0] FRAME_ETB   = 8'h17;

   // Line end characters
   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam logic [7:0] CHAR_CR = 8'h0D;

   // Item kinds
   localparam logic MODE_CHAR = 1'b0;
   localparam logic MODE_TICK = 1'b1;

   typedef struct packed {
      logic       mode;
      logic [7:0] char_byte;
   } req_word_type;

   typedef struct packed {
      logic                       line_bit;
      logic [BIT_INDEX_WIDTH-1:0] bit_index;
      logic                       last_bit;
   } rsp_word_type;

endpackage

// ----- src/lmfs_line_builder.sv -----
module lmfs_line_builder #(
   parameter int LINE_BYTES = lmfs_pkg::MESSAGE_BYTES_DEFAULT - 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    char_fire,
   input  logic [7:0]              char_byte,
   output logic                    push,
   output logic [LINE_BYTES*8-1:0] push_data
);
   import lmfs_pkg::*;

   localparam int LW = $clog2(LINE_BYTES + 1);

   logic [7:0]    store_ff [LINE_BYTES];
   logic [7:0]    store_in [LINE_BYTES];
   logic [LW-1:0] len_ff;
   logic [LW-1:0] len_in;
   logic          is_end;

   always_comb begin
      is_end   = ((char_byte == CHAR_LF) || (char_byte == CHAR_CR)) && (len_ff != '0);
      store_in = store_ff;
      len_in   = len_ff;
      push     = 1'b0;
      if (char_fire) begin
         if (is_end) begin
            // The terminator lands only if the line is not already full.
            for (int i = 0; i < LINE_BYTES; i++) begin
               if (LW'(i) == len_ff) begin
                  store_in[i] = 8'h00;
               end
            end
            push   = 1'b1;
            len_in = '0;
         end else if (len_ff < LW'(LINE_BYTES)) begin
            for (int i = 0; i < LINE_BYTES; i++) begin
               if (LW'(i) == len_ff) begin
                  store_in[i] = char_byte;
               end
            end
            len_in = len_ff + LW'(1);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < LINE_BYTES; i++) begin
         push_data[i*8 +: 8] = store_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
         for (int i = 0; i < LINE_BYTES; i++) begin
            store_ff[i] <= 8'h00;
         end
      end else begin
         len_ff   <= len_in;
         store_ff <= store_in;
      end
   end

endmodule

// ----- src/lmfs_msg_queue.sv -----
module lmfs_msg_queue #(
   parameter int QUEUE_DEPTH = lmfs_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int LINE_BYTES  = lmfs_pkg::MESSAGE_BYTES_DEFAULT - 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  logic [LINE_BYTES*8-1:0] push_data,
   input  logic                    pop,
   output logic                    nonempty,
   output logic [LINE_BYTES*8-1:0] payload
);
   import lmfs_pkg::*;

   localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int SW = CW + 1;

   logic [LINE_BYTES*8-1:0] mem [QUEUE_DEPTH];
   logic [LINE_BYTES*8-1:0] payload_ff;
   logic [IW-1:0]           head_ff;
   logic [IW-1:0]           head_in;
   logic [CW-1:0]           count_ff;
   logic [CW-1:0]           count_in;
   logic [SW-1:0]           tail_sum;
   logic [SW-1:0]           tail_wrap;
   logic [IW-1:0]           tail;
   logic                    push_ok;
   logic                    pop_ok;

   always_comb begin
      tail_sum  = SW'(head_ff) + SW'(count_ff);
      tail_wrap = (tail_sum >= SW'(QUEUE_DEPTH)) ? (tail_sum - SW'(QUEUE_DEPTH)) : tail_sum;
      tail      = IW'(tail_wrap);
      // A full queue drops the finished line.
      push_ok   = push && (count_ff != CW'(QUEUE_DEPTH));
      pop_ok    = pop && (count_ff != '0);
      head_in   = head_ff;
      count_in  = count_ff;
      if (pop_ok) begin
         head_in  = (head_ff == IW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + IW'(1);
         count_in = count_ff - CW'(1);
      end else if (push_ok) begin
         count_in = count_ff + CW'(1);
      end
   end

   assign nonempty = (count_ff != '0);
   assign payload  = payload_ff;

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem[tail] <= push_data;
      end
      if (pop_ok) begin
         payload_ff <= mem[head_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(QUEUE_DEPTH))
      else $error("message queue count beyond depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (push_ok && !pop_ok) |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("accepted push did not grow the queue");

endmodule

// ----- src/lmfs_frame_tx.sv -----
module lmfs_frame_tx #(
   parameter int LINE_BYTES = lmfs_pkg::MESSAGE_BYTES_DEFAULT - 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         tick_fire,
   input  logic [7:0]                   station_id,
   input  logic                         q_nonempty,
   input  logic [LINE_BYTES*8-1:0]      payload,
   output logic                         pop,
   output logic                         res_valid,
   output lmfs_pkg::rsp_word_type       res_word
);
   import lmfs_pkg::*;

   localparam int FRAME_BITS = (LINE_BYTES + 5) * 8;
   localparam int PW         = $clog2(FRAME_BITS + 1);
   localparam int BW         = PW - 3;

   logic [PW-1:0] pos_ff;
   logic [PW-1:0] pos_in;
   logic [PW-1:0] pos_cur;
   logic [BW-1:0] byte_idx;
   logic [7:0]    body_byte;
   logic [7:0]    cur_byte;
   logic          idle;

   always_comb begin
      idle      = (pos_ff >= PW'(FRAME_BITS));
      pop       = tick_fire && idle && q_nonempty;
      res_valid = tick_fire && (!idle || q_nonempty);
      pos_cur   = idle ? '0 : pos_ff;
      pos_in    = res_valid ? (pos_cur + PW'(1)) : pos_ff;
      byte_idx  = pos_cur[PW-1:3];

      // The first bit of a frame is header, so the payload register,
      // loaded by the pop, is ready long before it is needed.
      body_byte = FRAME_ETB;
      for (int i = 0; i < LINE_BYTES; i++) begin
         if (byte_idx == BW'(i + 4)) begin
            body_byte = payload[i*8 +: 8];
         end
      end
      priority if (byte_idx == BW'(0)) begin
         cur_byte = FRAME_SYNC;
      end else if (byte_idx == BW'(1)) begin
         cur_byte = FRAME_SYN;
      end else if (byte_idx == BW'(2)) begin
         cur_byte = FRAME_STX;
      end else if (byte_idx == BW'(3)) begin
         cur_byte = station_id;
      end else begin
         cur_byte = body_byte;
      end

      res_word.line_bit  = cur_byte[3'd7 - pos_cur[2:0]];
      res_word.bit_index = BIT_INDEX_WIDTH'(pos_cur);
      res_word.last_bit  = (pos_cur == PW'(FRAME_BITS - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= PW'(FRAME_BITS);
      end else begin
         pos_ff <= pos_in;
      end
   end

   a_last_idles: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res_word.last_bit) |=> (pos_ff == PW'(FRAME_BITS)))
      else $error("serializer not idle after the last bit");

   a_pop_starts: assert property (@(posedge clock) disable iff (reset)
      pop |-> (res_valid && (pos_cur == '0)))
      else $error("pop without the first frame bit");

endmodule

// ----- src/line_message_frame_serializer.sv -----
// Line message frame serializer.
//
// The request channel (req_valid, req_stall, req_data) carries one word per
// item: a received character (mode 0) or a bit-period tick (mode 1). Each
// character builds up a line; a CR or LF on a non-empty line queues it as a
// message. Each tick sends one frame bit, MSB first, on the response channel
// (rsp_valid, rsp_stall, rsp_data), with its position and a last-bit flag.
// A tick that finds the serializer idle and the queue empty gives no word.
// The csr channel writes the station identifier byte; csr_ready is always
// high, and writes are expected only while the block is idle.
//
// A request word is taken into an input register, handled once the output
// buffer has room for its result, and its response word is written into the
// output buffer. One request word is taken every cycle while the receiver
// keeps up.
// Synchronous reset empties the line and queue, idles the serializer and
// sets the station identifier to 87. If the receiver stalls, a two-word
// output buffer absorbs the words in flight, after which req_stall rises
// until the receiver takes a word again.
module line_message_frame_serializer #(
   parameter int QUEUE_DEPTH   = lmfs_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int MESSAGE_BYTES = lmfs_pkg::MESSAGE_BYTES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  lmfs_pkg::req_word_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output lmfs_pkg::rsp_word_type rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [7:0]             csr_data
);
   import lmfs_pkg::*;

   localparam int LINE_BYTES = MESSAGE_BYTES - 1;

   // Input register
   logic         s1_valid_ff;
   logic         s1_valid_in;
   req_word_type s1_word_ff;

   // Station identifier register
   logic [7:0] station_id_ff;

   // Output buffer: slot zero drives the response port, slot one is the skid.
   rsp_word_type slot0_ff;
   rsp_word_type slot1_ff;
   logic [1:0]   out_count_ff;
   logic [1:0]   out_count_in;
   logic         out_pop;
   logic         wr_slot1;

   logic                    fire;
   logic                    req_take;
   logic                    char_fire;
   logic                    tick_fire;
   logic                    line_push;
   logic [LINE_BYTES*8-1:0] line_data;
   logic                    q_pop;
   logic                    q_nonempty;
   logic [LINE_BYTES*8-1:0] q_payload;
   logic                    res_valid;
   rsp_word_type            res_word;

   // The held word is handled only when the buffer has room for its result.
   assign fire      = s1_valid_ff && (out_count_ff != 2'd2);
   assign req_stall = s1_valid_ff && !fire;
   assign req_take  = req_valid && !req_stall;
   assign char_fire = fire && (s1_word_ff.mode == MODE_CHAR);
   assign tick_fire = fire && (s1_word_ff.mode == MODE_TICK);
   assign csr_ready = 1'b1;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (fire) begin
         s1_valid_in = 1'b0;
      end
   end

   lmfs_line_builder #(
      .LINE_BYTES (LINE_BYTES)
   ) u_line (
      .clock     (clock),
      .reset     (reset),
      .char_fire (char_fire),
      .char_byte (s1_word_ff.char_byte),
      .push      (line_push),
      .push_data (line_data)
   );

   lmfs_msg_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .LINE_BYTES  (LINE_BYTES)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (line_push),
      .push_data (line_data),
      .pop       (q_pop),
      .nonempty  (q_nonempty),
      .payload   (q_payload)
   );

   lmfs_frame_tx #(
      .LINE_BYTES (LINE_BYTES)
   ) u_frame (
      .clock      (clock),
      .reset      (reset),
      .tick_fire  (tick_fire),
      .station_id (station_id_ff),
      .q_nonempty (q_nonempty),
      .payload    (q_payload),
      .pop        (q_pop),
      .res_valid  (res_valid),
      .res_word   (res_word)
   );

   // Output buffer bookkeeping. A new word goes behind whatever remains.
   always_comb begin
      out_pop      = (out_count_ff != 2'd0) && !rsp_stall;
      wr_slot1     = (out_count_ff == 2'd1) && !out_pop;
      out_count_in = out_count_ff + {1'b0, res_valid} - {1'b0, out_pop};
   end

   assign rsp_valid = (out_count_ff != 2'd0);
   assign rsp_data  = slot0_ff;

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_word_ff <= req_data;
      end
      if (res_valid && wr_slot1) begin
         slot1_ff <= res_word;
      end
      // A fresh word bound for slot zero takes the place of the skid word.
      if (res_valid && !wr_slot1) begin
         slot0_ff <= res_word;
      end else if (out_pop) begin
         slot0_ff <= slot1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         out_count_ff  <= 2'd0;
         station_id_ff <= STATION_ID_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_count_ff <= out_count_in;
         if (csr_valid && csr_ready) begin
            station_id_ff <= csr_data;
         end
      end
   end

   a_buffer_bound: assert property (@(posedge clock) disable iff (reset)
      out_count_ff != 2'd3)
      else $error("output buffer overflow");

endmodule
